// ===== hw/rtl/dq_pkg.sv =====
// Shared types and codes for the bounded double-ended queue.
// No dependencies; used by dq_ctrl, dq_datapath and bounded_deque.
package dq_pkg;

  // Operation codes carried by func
  localparam logic [1:0] FN_INS_L = 2'd0;
  localparam logic [1:0] FN_INS_R = 2'd1;
  localparam logic [1:0] FN_REM_L = 2'd2;
  localparam logic [1:0] FN_REM_R = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_DENIED = 2'd3;

  // Restriction register bits
  localparam int MODE_NO_INS_R = 0;
  localparam int MODE_NO_REM_R = 1;

  // Field widths
  localparam int VAL_W  = 32;
  localparam int OCC_W  = 5;
  localparam int MODE_W = 2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;     // latch the incoming item
    logic execute;  // access the store and update pointers
    logic load;     // move the result into the output register
  } cmd_t;

endpackage

// ===== hw/rtl/dq_ctrl.sv =====
// Controller for the bounded double-ended queue: sequences one item
// through execute and load, and owns both handshakes. Uses dq_pkg.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // Output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  assign in_stall    = (state != S_IDLE);
  assign cmd.take    = (state == S_IDLE) && in_valid;
  assign cmd.execute = (state == S_EXEC);
  assign cmd.load    = (state == S_LOAD) && out_free;

  // Advance through the item's steps
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/dq_datapath.sv =====
// Datapath for the bounded double-ended queue: entry store, head and count
// registers, restriction register and output register. Uses dq_pkg.
module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic [1:0]               func,
  input  logic signed [VAL_W-1:0]  value_in,
  input  logic                     cfg_wen,
  input  logic [MODE_W-1:0]        cfg_wdata,
  output logic signed [VAL_W-1:0]  value_out,
  output logic [1:0]               status,
  output logic [OCC_W-1:0]         occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rd_data;
  logic [1:0]        op_func;
  logic [VAL_W-1:0]  op_value;
  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  logic [MODE_W-1:0] mode;
  logic [1:0]        res_status;
  logic              res_take;
  logic [CW-1:0]     res_count;

  logic          denied;
  logic          is_ins;
  logic          full;
  logic          empty;
  logic          ok;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] offset;
  logic [SW-1:0] pos_sum;
  logic [AW-1:0] tail_pos;
  logic [AW-1:0] addr;
  logic [1:0]    st_now;
  logic [CW-1:0] count_next;
  logic [AW-1:0] head_next;

  // Decode the operation against restriction, full and empty
  assign denied = ((op_func == FN_INS_R) && mode[MODE_NO_INS_R]) ||
                  ((op_func == FN_REM_R) && mode[MODE_NO_REM_R]);
  assign is_ins = !op_func[1];
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign ok     = !denied && (is_ins ? !full : !empty);

  // Wrap the head one step either way
  assign head_dec = (head == '0) ? LAST : head - AW'(1);
  assign head_inc = (head == LAST) ? '0 : head + AW'(1);

  // Right end: head + count for insert, head + count - 1 for removal
  assign offset   = (op_func == FN_REM_R) ? count - CW'(1) : count;
  assign pos_sum  = SW'(head) + SW'(offset);
  assign tail_pos = (pos_sum >= SW'(DEPTH)) ? AW'(pos_sum - SW'(DEPTH)) : AW'(pos_sum);

  // Select the store address and the new pointers
  always_comb begin
    addr       = head;
    head_next  = head;
    count_next = count;
    case (op_func)
      FN_INS_L: begin
        addr = head_dec;
        if (ok) begin
          head_next  = head_dec;
          count_next = count + CW'(1);
        end
      end
      FN_INS_R: begin
        addr = tail_pos;
        if (ok) count_next = count + CW'(1);
      end
      FN_REM_L: begin
        addr = head;
        if (ok) begin
          head_next  = head_inc;
          count_next = count - CW'(1);
        end
      end
      FN_REM_R: begin
        addr = tail_pos;
        if (ok) count_next = count - CW'(1);
      end
      default: begin
        addr = head;
      end
    endcase
  end

  // Status of the operation, restriction first
  always_comb begin
    if (denied) begin
      st_now = ST_DENIED;
    end else if (is_ins && full) begin
      st_now = ST_FULL;
    end else if (!is_ins && empty) begin
      st_now = ST_EMPTY;
    end else begin
      st_now = ST_DONE;
    end
  end

  // Entry store: a write on each successful insert and one registered read per execute
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (ok && is_ins) begin
        mem[addr] <= op_value;
      end
      rd_data <= mem[addr];
    end
  end

  // Hold pointers and restriction register
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      mode  <= '0;
    end else begin
      if (cmd.execute) begin
        head  <= head_next;
        count <= count_next;
      end
      if (cfg_wen) begin
        mode <= cfg_wdata;
      end
    end
  end

  // Latch the item and the pending result
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_func  <= func;
      op_value <= value_in;
    end
    if (cmd.execute) begin
      res_status <= st_now;
      res_take   <= ok && !is_ins;
      res_count  <= count_next;
    end
    if (cmd.load) begin
      value_out <= res_take ? $signed(rd_data) : '0;
      status    <= res_status;
      occupancy <= OCC_W'(res_count);
    end
  end

endmodule

// ===== hw/rtl/bounded_deque.sv =====
// Bounded double-ended queue of signed 32-bit values in a circular store.
// Each accepted item is latched, then the entry store is accessed with a registered
// read, then the result is loaded into the output register once that register is free.
// No new item is taken until the current one is in the output register, so each item
// passes the accept step, the registered read port and the separate load in turn.
// Reset clears head, count, restriction register and output valid;
// the entry store is not cleared and no clearing pass is needed.
module bounded_deque
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               func,
  input  logic signed [VAL_W-1:0]  value_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  value_out,
  output logic [1:0]               status,
  output logic [OCC_W-1:0]         occupancy,
  input  logic                     cfg_wen,
  input  logic [MODE_W-1:0]        cfg_wdata
);

  cmd_t cmd;

  // Sequence each item
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Store, pointers and result registers
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .func      (func),
    .value_in  (value_in),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .value_out (value_out),
    .status    (status),
    .occupancy (occupancy)
  );

`ifndef NO_ASSERTIONS
  // One item at a time: an accepted item blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in work");

  // Failed operations carry a zero value
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_DONE)) |-> (value_out == '0))
    else $error("non-zero value with failure status");

  // Occupancy never exceeds the store depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(occupancy) <= DEPTH))
    else $error("occupancy beyond depth");
`endif

endmodule

// ===== tb/bounded_deque_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bounded_deque: random and directed deque traffic with random
// input gaps and random result-side stalls. Depends on dq_pkg and the bounded_deque RTL.

import dq_pkg::*;

// Restriction register settings
typedef enum logic [MODE_W-1:0] {
  MODE_OPEN         = 2'd0,
  MODE_NO_RIGHT_IN  = 2'd1,
  MODE_NO_RIGHT_OUT = 2'd2,
  MODE_NO_RIGHT     = 2'd3
} restrict_mode_t;

// Tracks the deque contents and holds the results still owed by the block
class deque_scoreboard;
  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              code;
    logic [OCC_W-1:0]        occ;
  } deque_result_t;

  localparam int SLOTS = 16;

  logic signed [VAL_W-1:0] slots [SLOTS];
  logic [3:0]              head;
  logic [OCC_W-1:0]        count;
  logic [MODE_W-1:0]       mode;
  deque_result_t           owed_results [$];
  int                      errors;
  int                      seen [4];

  function new();
    head   = '0;
    count  = '0;
    mode   = MODE_OPEN;
    errors = 0;
    foreach (seen[i]) seen[i] = 0;
  endfunction

  function void set_mode(logic [MODE_W-1:0] m);
    mode = m;
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  // Work out the result of one accepted item and advance the deque
  function void note_op(logic [1:0] op, logic signed [VAL_W-1:0] val);
    deque_result_t r;
    logic [3:0]    idx;
    r.value = '0;
    r.code  = ST_DONE;
    if ((op == FN_INS_R && mode[MODE_NO_INS_R]) ||
        (op == FN_REM_R && mode[MODE_NO_REM_R])) begin
      r.code = ST_DENIED;
    end else if (op == FN_INS_L || op == FN_INS_R) begin
      if (count == SLOTS) begin
        r.code = ST_FULL;
      end else if (op == FN_INS_L) begin
        head = head - 4'd1;
        slots[head] = val;
        count = count + 1'b1;
      end else begin
        idx = head + count[3:0];
        slots[idx] = val;
        count = count + 1'b1;
      end
    end else begin
      if (count == 0) begin
        r.code = ST_EMPTY;
      end else if (op == FN_REM_L) begin
        r.value = slots[head];
        head = head + 4'd1;
        count = count - 1'b1;
      end else begin
        count = count - 1'b1;
        idx = head + count[3:0];
        r.value = slots[idx];
      end
    end
    r.occ = count;
    owed_results.push_back(r);
  endfunction

  // Compare one accepted result with the oldest one owed
  function void check_result(logic signed [VAL_W-1:0] value, logic [1:0] code,
                             logic [OCC_W-1:0] occ);
    deque_result_t r;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result value_out %0d status %0d occupancy %0d",
               $time, value, code, occ);
      errors++;
      return;
    end
    r = owed_results.pop_front();
    seen[r.code]++;
    if (value !== r.value) begin
      $display("%0t: value_out expected %0d got %0d", $time, r.value, value);
      errors++;
    end
    if (code !== r.code) begin
      $display("%0t: status expected %0d got %0d", $time, r.code, code);
      errors++;
    end
    if (occ !== r.occ) begin
      $display("%0t: occupancy expected %0d got %0d", $time, r.occ, occ);
      errors++;
    end
  endfunction
endclass

module bounded_deque_tb;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 85;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              func = FN_INS_L;
  logic signed [VAL_W-1:0] value_in = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] value_out;
  logic [1:0]              status;
  logic [OCC_W-1:0]        occupancy;
  logic                    cfg_wen = 1'b0;
  logic [MODE_W-1:0]       cfg_wdata = MODE_OPEN;

  deque_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              idle_pct = 30;
  int              stall_pct = 30;
  int              stall_left = 0;
  int              cycles = 0;
  int              items_sent = 0;

  restrict_mode_t  phase_modes [8] = '{MODE_OPEN, MODE_NO_RIGHT_IN, MODE_NO_RIGHT_OUT,
                                       MODE_NO_RIGHT, MODE_OPEN, MODE_NO_RIGHT_OUT,
                                       MODE_NO_RIGHT_IN, MODE_OPEN};

  bounded_deque dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out),
    .status    (status),
    .occupancy (occupancy),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Note accepted items first, then check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_op(func, value_in);
      if (out_valid && !out_stall) sb.check_result(value_out, status, occupancy);
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Present one item, after an optional idle burst, and hold it until taken
  task automatic send_op(input logic [1:0] op, input logic signed [VAL_W-1:0] val);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= op;
    value_in <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input restrict_mode_t m);
    settle();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    sb.set_mode(m);
  endtask

  initial begin
    int fill_pct;
    logic [1:0] op;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Removals from an empty deque
    send_op(FN_REM_L, 32'sd7);
    send_op(FN_REM_R, -32'sd7);
    // Extreme values at both ends, then take the outer two back
    send_op(FN_INS_L, 32'sh7FFF_FFFF);
    send_op(FN_INS_R, 32'sh8000_0000);
    send_op(FN_INS_L, '0);
    send_op(FN_INS_R, -32'sd1);
    send_op(FN_REM_R, '0);
    send_op(FN_REM_L, '0);
    // Fill to capacity, wrapping the head, then insert into a full deque
    for (int i = 0; i < 14; i++) send_op(i[0] ? FN_INS_R : FN_INS_L, $urandom);
    send_op(FN_INS_L, 32'sd5);
    send_op(FN_INS_R, -32'sd5);

    // Random phases, one restriction setting each; the last one runs without gaps
    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      quiet     = (p == 7);
      idle_pct  = (p % 3 == 2) ? 0 : 30;
      stall_pct = (p % 3 == 1) ? 0 : 30;
      // Both right-hand operations, so refusals show up in every restricted phase
      send_op(FN_INS_R, pick_value());
      send_op(FN_REM_R, pick_value());
      fill_pct = 80;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 24 == 0) fill_pct = (fill_pct == 80) ? 25 : 80;
        if ($urandom_range(0, 99) < fill_pct)
          op = $urandom_range(0, 1) ? FN_INS_R : FN_INS_L;
        else
          op = $urandom_range(0, 1) ? FN_REM_R : FN_REM_L;
        send_op(op, pick_value());
      end
    end

    settle();
    $display("%0d items over all four restriction settings, filled and drained past the wrap",
             items_sent);
    $display("results: %0d done, %0d empty, %0d full, %0d refused",
             sb.seen[ST_DONE], sb.seen[ST_EMPTY], sb.seen[ST_FULL], sb.seen[ST_DENIED]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/dq_pkg.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/bounded_deque.sv
tb/bounded_deque_tb.sv
